### rtl/soft_clip_audio_mixer_assert.svh
// ----------------------------------------------------------------------------
// soft clip audio mixer assertion macros
// shared property forms for the checker files of the mixer
// ----------------------------------------------------------------------------
`ifndef SOFT_CLIP_AUDIO_MIXER_ASSERT_SVH
`define SOFT_CLIP_AUDIO_MIXER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SCAM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SCAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/scam_pkg.sv
// ----------------------------------------------------------------------------
// scam_pkg
// types, widths and helper functions shared by the soft clip mixer modules
// ----------------------------------------------------------------------------
package scam_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int BYTE_W        = 8;
    localparam int MAX_LANES     = 8;
    localparam int LANES_DEFAULT = 8;
    localparam int MASK_W        = MAX_LANES;
    localparam int S_TDATA_W     = MAX_LANES * SAMPLE_W;

    localparam int DEPTH_W = 5;
    localparam int LIM_W   = 15;             // full scale limit, at most 2^15-1
    localparam int SUM_W   = SAMPLE_W + 1;   // a+b
    localparam int WIDE_W  = 2 * SAMPLE_W;   // a*b and (a+b)*L before abs
    localparam int PROD_W  = 31;             // |a*b| <= 2^30
    localparam int NUM_W   = 31;             // |(a+b)*L| < 2^31
    localparam int Q1_W    = 24;             // |a*b|/L with L >= 127
    localparam int DEN_W   = 24;             // L + |a*b|/L
    localparam int Q2_W    = 17;             // |mix| <= |a+b| <= 2^16

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BYTES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_SAMPLE = 1'd1;

    localparam logic [1:0]         SAMPLE_BYTES_RST    = 2'd2;
    localparam logic [DEPTH_W-1:0] BITS_PER_SAMPLE_RST = 5'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN           = 5'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX           = 5'd16;

    typedef logic [MAX_LANES-1:0][SAMPLE_W-1:0] t_samples;

    typedef struct packed {
        logic             wide;   // two byte sample words
        logic [LIM_W-1:0] lim;    // full scale limit L
    } t_cfg;

    typedef struct packed {
        t_samples            samples;
        logic [MASK_W-1:0]   mask;
        logic [SAMPLE_W-1:0] acc;     // running mix, cut to the sample width
    } t_cell_data;

    typedef struct packed {
        logic             num_neg;
        logic [NUM_W-1:0] num_abs;
        logic             active;
        t_cell_data       data;
    } t_div1_pay;

    typedef struct packed {
        logic       num_neg;
        logic       active;
        t_cell_data data;
    } t_div2_pay;

    function automatic t_cfg decode_cfg(input logic [1:0]         sample_bytes,
                                        input logic [DEPTH_W-1:0] bits_per_sample);
        logic [DEPTH_W-1:0] depth;
        logic [LIM_W:0]     full;
        t_cfg               cfg;
        depth = bits_per_sample;
        if (depth < DEPTH_MIN) depth = DEPTH_MIN;
        if (depth > DEPTH_MAX) depth = DEPTH_MAX;
        full     = (LIM_W+1)'(1) << (depth - DEPTH_W'(1));
        // 0 and 1 byte act as one byte, 2 and 3 as two
        cfg.wide = sample_bytes[1];
        cfg.lim  = full[LIM_W-1:0] - LIM_W'(1);
        return cfg;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sign_extend(input logic [SAMPLE_W-1:0] w,
                                                               input logic wide);
        return wide ? w : {{(SAMPLE_W-BYTE_W){w[BYTE_W-1]}}, w[BYTE_W-1:0]};
    endfunction

    function automatic logic [SAMPLE_W-1:0] trim_word(input logic [SAMPLE_W-1:0] w,
                                                      input logic wide);
        return wide ? w : {{(SAMPLE_W-BYTE_W){1'b0}}, w[BYTE_W-1:0]};
    endfunction

endpackage

### rtl/scam_udiv.sv
// ----------------------------------------------------------------------------
// scam_udiv
// pipelined unsigned restoring divider, one quotient bit per stage,
// carries a side word alongside each division
// ----------------------------------------------------------------------------
module scam_udiv #(
    parameter int N_W = 31,
    parameter int D_W = 15,
    parameter int Q_W = 24,
    parameter int P_W = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    input  logic [P_W-1:0] i_payload,
    output logic           o_valid,
    output logic [Q_W-1:0] o_quotient,
    output logic [P_W-1:0] o_payload
);

    // dividend < divisor * 2^Q_W, so the live part of the remainder at bit k
    // always fits in D_W+1 bits starting at k
    localparam int R_W = Q_W + D_W;

    logic           w_valid_in [Q_W];
    logic [R_W-1:0] w_rem_in   [Q_W];
    logic [D_W-1:0] w_div_in   [Q_W];
    logic [Q_W-1:0] w_quo_in   [Q_W];
    logic [P_W-1:0] w_pay_in   [Q_W];

    logic           r_valid [Q_W];
    logic [Q_W-1:0] r_quo   [Q_W];
    logic [P_W-1:0] r_pay   [Q_W];
    logic [R_W-1:0] r_rem   [Q_W-1];
    logic [D_W-1:0] r_div   [Q_W-1];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int K = Q_W - 1 - s;

        logic [D_W:0]   w_top;
        logic [D_W+1:0] w_diff;
        logic           w_fit;
        logic [Q_W-1:0] w_quo_nx;

        if (s == 0) begin : g_head
            assign w_valid_in[s] = i_valid;
            assign w_rem_in[s]   = R_W'(i_dividend);
            assign w_div_in[s]   = i_divisor;
            assign w_quo_in[s]   = '0;
            assign w_pay_in[s]   = i_payload;
        end else begin : g_body
            assign w_valid_in[s] = r_valid[s-1];
            assign w_rem_in[s]   = r_rem[s-1];
            assign w_div_in[s]   = r_div[s-1];
            assign w_quo_in[s]   = r_quo[s-1];
            assign w_pay_in[s]   = r_pay[s-1];
        end

        assign w_top  = w_rem_in[s][K +: D_W+1];
        assign w_diff = {1'b0, w_top} - {2'b00, w_div_in[s]};
        assign w_fit  = ~w_diff[D_W+1];

        always_comb begin
            w_quo_nx = w_quo_in[s];
            w_quo_nx[K] = w_fit;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= w_valid_in[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= w_quo_nx;
                r_pay[s] <= w_pay_in[s];
            end
        end

        if (s < Q_W - 1) begin : g_carry
            logic [R_W-1:0] w_rem_nx;

            always_comb begin
                w_rem_nx = w_rem_in[s];
                if (w_fit) w_rem_nx[K +: D_W+1] = w_diff[D_W:0];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_rem_nx;
                    r_div[s] <= w_div_in[s];
                end
            end
        end
    end

    assign o_valid    = r_valid[Q_W-1];
    assign o_quotient = r_quo[Q_W-1];
    assign o_payload  = r_pay[Q_W-1];

endmodule

### rtl/scam_cell.sv
// ----------------------------------------------------------------------------
// scam_cell
// one lane of the mixing chain: folds its lane into the running mix with
// (a+b)*L / (L + |a*b|/L) when the lane is present, else passes the mix on
// ----------------------------------------------------------------------------
module scam_cell #(
    parameter int LANE = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  scam_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    input  scam_pkg::t_cell_data  i_data,
    output logic                  o_valid,
    output scam_pkg::t_cell_data  o_data
);

    import scam_pkg::*;

    // stage 1: a*b and a+b
    logic signed [SAMPLE_W-1:0] w_a;
    logic signed [SAMPLE_W-1:0] w_b;
    logic                       r_s1_valid;
    logic signed [WIDE_W-1:0]   r_s1_prod;
    logic signed [SUM_W-1:0]    r_s1_sum;
    logic                       r_s1_active;
    t_cell_data                 r_s1_data;

    assign w_a = sign_extend(i_data.acc, i_cfg.wide);
    assign w_b = sign_extend(i_data.samples[LANE], i_cfg.wide);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_prod   <= WIDE_W'(w_a) * WIDE_W'(w_b);
            r_s1_sum    <= SUM_W'(w_a) + SUM_W'(w_b);
            r_s1_active <= i_data.mask[LANE];
            r_s1_data   <= i_data;
        end
    end

    // stage 2: |a*b| and (a+b)*L
    logic signed [WIDE_W-1:0] w_prod_abs;
    logic signed [WIDE_W-1:0] w_num;
    logic                     r_s2_valid;
    logic [PROD_W-1:0]        r_s2_prod_abs;
    logic signed [WIDE_W-1:0] r_s2_num;
    logic                     r_s2_active;
    t_cell_data               r_s2_data;

    assign w_prod_abs = r_s1_prod[WIDE_W-1] ? -r_s1_prod : r_s1_prod;
    assign w_num      = WIDE_W'(r_s1_sum) * WIDE_W'(signed'({1'b0, i_cfg.lim}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_prod_abs <= w_prod_abs[PROD_W-1:0];
            r_s2_num      <= w_num;
            r_s2_active   <= r_s1_active;
            r_s2_data     <= r_s1_data;
        end
    end

    // |a*b| / L
    logic signed [WIDE_W-1:0] w_num_neg;
    t_div1_pay                w_pay1_in;
    t_div1_pay                w_pay1_out;
    logic                     w_q1_valid;
    logic [Q1_W-1:0]          w_q1;

    assign w_num_neg = -r_s2_num;

    always_comb begin
        w_pay1_in.num_neg = r_s2_num[WIDE_W-1];
        w_pay1_in.num_abs = r_s2_num[WIDE_W-1] ? w_num_neg[NUM_W-1:0] : r_s2_num[NUM_W-1:0];
        w_pay1_in.active  = r_s2_active;
        w_pay1_in.data    = r_s2_data;
    end

    scam_udiv #(
        .N_W (PROD_W),
        .D_W (LIM_W),
        .Q_W (Q1_W),
        .P_W ($bits(t_div1_pay))
    ) u_div_prod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (i_en),
        .i_valid    (r_s2_valid),
        .i_dividend (r_s2_prod_abs),
        .i_divisor  (i_cfg.lim),
        .i_payload  (w_pay1_in),
        .o_valid    (w_q1_valid),
        .o_quotient (w_q1),
        .o_payload  (w_pay1_out)
    );

    // |(a+b)*L| / (L + |a*b|/L), sign put back afterwards
    logic [DEN_W-1:0] w_den;
    t_div2_pay        w_pay2_in;
    t_div2_pay        w_pay2_out;
    logic             w_q2_valid;
    logic [Q2_W-1:0]  w_q2;

    assign w_den = DEN_W'(i_cfg.lim) + w_q1;

    always_comb begin
        w_pay2_in.num_neg = w_pay1_out.num_neg;
        w_pay2_in.active  = w_pay1_out.active;
        w_pay2_in.data    = w_pay1_out.data;
    end

    scam_udiv #(
        .N_W (NUM_W),
        .D_W (DEN_W),
        .Q_W (Q2_W),
        .P_W ($bits(t_div2_pay))
    ) u_div_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (i_en),
        .i_valid    (w_q1_valid),
        .i_dividend (w_pay1_out.num_abs),
        .i_divisor  (w_den),
        .i_payload  (w_pay2_in),
        .o_valid    (w_q2_valid),
        .o_quotient (w_q2),
        .o_payload  (w_pay2_out)
    );

    // final stage: cut to the sample width, negative mixes keep the top bit set
    logic [Q2_W-1:0]     w_mix;
    logic [SAMPLE_W-1:0] w_word;
    t_cell_data          n_data;
    logic                r_s3_valid;
    t_cell_data          r_s3_data;

    always_comb begin
        w_mix  = w_pay2_out.num_neg ? -w_q2 : w_q2;
        w_word = trim_word(w_mix[SAMPLE_W-1:0], i_cfg.wide);
        if (w_pay2_out.num_neg && (w_q2 != '0)) begin
            if (i_cfg.wide) begin
                w_word[SAMPLE_W-1] = 1'b1;
            end else begin
                w_word[BYTE_W-1] = 1'b1;
            end
        end
        n_data = w_pay2_out.data;
        if (w_pay2_out.active) n_data.acc = w_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= w_q2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_s3_data <= n_data;
    end

    assign o_valid = r_s3_valid;
    assign o_data  = r_s3_data;

endmodule

### rtl/soft_clip_audio_mixer.sv
// ----------------------------------------------------------------------------
// soft_clip_audio_mixer
// mixes one sample position of up to LANES streams with the soft clip fold
// (a+b)*L / (L + |a*b|/L), one lane cell after the other
//
// channel   dir  signals                         word
// s_axis    in   tvalid tready tdata tuser       sample_0..7, present_mask
// m_axis    out  tvalid tready tdata             mixed_sample
// cfg       in   i_cfg_we i_cfg_index i_cfg_wdata sample_bytes, bits_per_sample
//
// one word per cycle while s_axis_tready is high; a result passes the input
// register, then lane cells 1..LANES-1 with two multiply stages and two
// bit-per-stage dividers of 24 and 17 stages each, then the output register
// reset is synchronous and clears the pipeline, output and skid valid bits;
// config returns to two byte words of 16 bits
// a stall on m_axis fills the skid register, which holds the whole chain and
// drops s_axis_tready until the output word is taken
// ----------------------------------------------------------------------------
module soft_clip_audio_mixer #(
    parameter int LANES = scam_pkg::LANES_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // sample_0 .. sample_7, 16 bits each, sample_0 lowest
    input  logic [scam_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // present_mask
    input  logic [scam_pkg::MASK_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // mixed_sample
    output logic [scam_pkg::SAMPLE_W-1:0]    m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [scam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [scam_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    import scam_pkg::*;

    // config registers
    logic [1:0]         r_sample_bytes;
    logic [DEPTH_W-1:0] r_bits_per_sample;
    t_cfg               w_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_bytes    <= SAMPLE_BYTES_RST;
            r_bits_per_sample <= BITS_PER_SAMPLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SAMPLE_BYTES:    r_sample_bytes    <= i_cfg_wdata[1:0];
                REG_BITS_PER_SAMPLE: r_bits_per_sample <= i_cfg_wdata;
            endcase
        end
    end

    assign w_cfg = decode_cfg(r_sample_bytes, r_bits_per_sample);

    // chain enable, held while the skid register is full
    logic w_en;
    logic r_skid_valid;

    assign w_en          = ~r_skid_valid;
    assign s_axis_tready = w_en;

    // input stage: lane 0 seeds the running mix
    logic       r_in_valid;
    t_cell_data r_in_data;
    t_cell_data n_in_data;

    always_comb begin
        n_in_data.samples = t_samples'(s_axis_tdata);
        n_in_data.mask    = s_axis_tuser;
        n_in_data.acc     = s_axis_tuser[0] ? trim_word(s_axis_tdata[SAMPLE_W-1:0], w_cfg.wide)
                                            : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_in_data <= n_in_data;
    end

    // lane cells
    logic       w_valid [LANES];
    t_cell_data w_data  [LANES];

    assign w_valid[0] = r_in_valid;
    assign w_data[0]  = r_in_data;

    for (genvar l = 1; l < LANES; l++) begin : g_lane
        scam_cell #(
            .LANE (l)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cfg   (w_cfg),
            .i_valid (w_valid[l-1]),
            .i_data  (w_data[l-1]),
            .o_valid (w_valid[l]),
            .o_data  (w_data[l])
        );
    end

    // output register with skid
    logic                w_push;
    logic                w_pop;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_word;
    logic [SAMPLE_W-1:0] r_skid_word;

    assign w_push = w_en & w_valid[LANES-1];
    assign w_pop  = r_out_valid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (r_skid_valid) begin
                if (w_pop) r_skid_valid <= 1'b0;
            end else if (w_push && r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (w_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) r_out_word <= r_skid_word;
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_word <= w_data[LANES-1].acc;
            end else begin
                r_out_word <= w_data[LANES-1].acc;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;

endmodule

### rtl/scam_checker.sv
// ----------------------------------------------------------------------------
// scam_checker
// port level checks of the mixer's stall and skid behavior
// ----------------------------------------------------------------------------
`include "soft_clip_audio_mixer_assert.svh"

module scam_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          i_s_tready,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [scam_pkg::SAMPLE_W-1:0] i_m_tdata
);

    // a stalled output word holds
    `SCAM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata), "output word changed while stalled")

    // the input side only closes when a word is already waiting at the output
    `SCAM_ASSERT_SAME(a_ready_needs_out, i_clk, i_rst_n, !i_s_tready, i_m_tvalid, "input ready low without a waiting output word")

    // the skid word cannot drain without an output handshake
    `SCAM_ASSERT_NEXT(a_ready_stays_low, i_clk, i_rst_n, !i_s_tready && !i_m_tready, !i_s_tready, "input ready rose without an output handshake")

    // one output handshake empties the skid register
    `SCAM_ASSERT_NEXT(a_ready_returns, i_clk, i_rst_n, !i_s_tready && i_m_tready && i_s_tvalid || !i_s_tready && i_m_tready && !i_s_tvalid, i_s_tready, "input ready stayed low after the output word was taken")

endmodule

bind soft_clip_audio_mixer scam_checker u_scam_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for soft_clip_audio_mixer: sample positions go in on
// s_axis, each accepted word is folded lane by lane in a scoreboard with the
// soft clip formula and the mixed word on m_axis is compared in order.
// runs under several sample formats, the saturating ones included, with random
// stalls on both streams
// ----------------------------------------------------------------------------

class mix_scoreboard;
    logic [1:0]  bytes_reg;
    logic [4:0]  depth_reg;
    logic [15:0] pending_mix[$];
    int unsigned lanes;
    int unsigned faults;
    int unsigned checked;

    function new(int unsigned n);
        lanes     = n;
        bytes_reg = scam_pkg::SAMPLE_BYTES_RST;
        depth_reg = scam_pkg::BITS_PER_SAMPLE_RST;
        faults    = 0;
        checked   = 0;
    endfunction

    // two's complement value of the low nb bits
    function longint widen(longint w, int unsigned nb);
        longint span;
        span = longint'(1) << nb;
        w    = w & (span - 1);
        return (w >= (span >> 1)) ? w - span : w;
    endfunction

    function void add_position(scam_pkg::t_samples lane, logic [7:0] present);
        int unsigned nb;
        int unsigned depth;
        longint      lim, top, wmask, acc, a, b, prod, v;
        nb    = (bytes_reg < 2'd2) ? 8 : 16;
        depth = depth_reg;
        if (depth < 8) depth = 8;
        if (depth > 16) depth = 16;
        lim   = (longint'(1) << (depth - 1)) - 1;
        wmask = (longint'(1) << nb) - 1;
        top   = longint'(1) << (nb - 1);
        acc   = present[0] ? (longint'(lane[0]) & wmask) : 0;
        for (int i = 1; i < lanes && i < 8; i++) begin
            if (present[i]) begin
                a    = widen(acc, nb);
                b    = widen(longint'(lane[i]), nb);
                prod = a * b;
                if (prod < 0) prod = -prod;
                v    = ((a + b) * lim) / (lim + prod / lim);
                // cut to the word, negative mixes keep the sign bit set
                acc  = v & wmask;
                if (v < 0) acc = acc | top;
            end
        end
        pending_mix.insert(pending_mix.size(), acc[15:0]);
    endfunction

    function void check_mix(logic [15:0] got);
        logic [15:0] want;
        checked++;
        if (pending_mix.size() == 0) begin
            faults++;
            if (faults <= 10)
                $display("mixed word %h arrived with nothing pending", got);
            return;
        end
        want = pending_mix.pop_front();
        if (got !== want) begin
            faults++;
            if (faults <= 10)
                $display("mix mismatch on word %0d: expected %h, got %h", checked, want, got);
        end
    endfunction
endclass

module tb;
    import scam_pkg::*;

    localparam int LANES       = LANES_DEFAULT;
    localparam int LATENCY     = 2 + 44 * (LANES - 1);
    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [MASK_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_SAMPLE_BYTES;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    mix_scoreboard sb;
    int unsigned   cycles = 0;
    int unsigned   idle_pct = 0;
    int unsigned   stall_left = 0;
    int unsigned   formats = 1;
    int unsigned   positions = 0;
    bit            calm = 1'b0;

    soft_clip_audio_mixer #(.LANES(LANES)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.add_position(s_axis_tdata, s_axis_tuser);
            positions++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_mix(m_axis_tdata);
    end

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(99) < idle_pct) begin
            stall_left    = $urandom_range(1, 17) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_position(input t_samples lane, input logic [7:0] present);
        int unsigned gap;
        if (!calm && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= lane;
        s_axis_tuser  <= present;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // drains the pipeline, then writes both format registers
    task automatic set_format(input logic [1:0] bytes, input logic [4:0] depth);
        logic [2:0] junk;
        junk = 3'($urandom_range(0, 7));
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_mix.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SAMPLE_BYTES;
        i_cfg_wdata <= {junk, bytes};
        @(negedge i_clk);
        i_cfg_index <= REG_BITS_PER_SAMPLE;
        i_cfg_wdata <= depth;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.bytes_reg = bytes;
        sb.depth_reg = depth;
        formats++;
    endtask

    task automatic send_random(input int unsigned count);
        t_samples   lane;
        logic [7:0] present;
        for (int n = 0; n < count; n++) begin
            for (int l = 0; l < MAX_LANES; l++) begin
                case ($urandom_range(0, 11))
                    0:       lane[l] = 16'h7FFF;
                    1:       lane[l] = 16'h8000;
                    2:       lane[l] = 16'h0000;
                    3:       lane[l] = 16'hFFFF;
                    4:       lane[l] = 16'h007F;
                    5:       lane[l] = 16'h0080;
                    6:       lane[l] = 16'hFF80;
                    default: lane[l] = 16'($urandom);
                endcase
            end
            case ($urandom_range(0, 11))
                0, 1:    present = 8'hFF;
                2:       present = 8'h00;
                3:       present = 8'h01 << $urandom_range(0, 7);
                default: present = 8'($urandom);
            endcase
            send_position(lane, present);
        end
    endtask

    int unsigned fmt_bytes [9] = '{2, 1, 0, 3, 1, 2, 2, 1, 2};
    int unsigned fmt_depth [9] = '{16, 8, 0, 31, 16, 8, 12, 5, 17};
    int unsigned fmt_count [9] = '{200, 150, 80, 100, 100, 100, 80, 60, 50};
    int unsigned fmt_idle  [9] = '{30, 20, 40, 25, 0, 30, 15, 35, 20};

    initial begin
        sb = new(LANES);
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset format: two byte words, 16 bit depth
        idle_pct = 20;
        send_position(t_samples'({8{16'hA5C3}}), 8'h00);
        send_position({{7{16'h1111}}, 16'h8000}, 8'h01);
        send_position({{6{16'h0000}}, 16'h7FFF, 16'h7FFF}, 8'h03);
        send_position({{6{16'h0000}}, 16'h8000, 16'h8000}, 8'h03);
        send_position({{6{16'h0000}}, 16'h8000, 16'h7FFF}, 8'h03);
        send_position(t_samples'({8{16'h7FFF}}), 8'hFF);
        send_position(t_samples'({8{16'h8000}}), 8'hFF);
        send_position(t_samples'({8{16'h4000}}), 8'hFE);
        send_position({16'h1234, {7{16'h7FFF}}}, 8'h80);
        send_position({4{16'hC000, 16'h3FFF}}, 8'hAA);
        send_position({4{16'hC000, 16'h3FFF}}, 8'h55);
        send_position(t_samples'({8{16'hFFFF}}), 8'hFF);
        send_position(t_samples'({8{16'h0000}}), 8'hFF);

        // one byte words, upper byte must be ignored
        set_format(2'd1, 5'd8);
        send_position(t_samples'({8{16'hFF7F}}), 8'hFF);
        send_position(t_samples'({8{16'hAB80}}), 8'hFF);
        send_position({{6{16'h0000}}, 16'h5A80, 16'h007F}, 8'h03);
        send_position(t_samples'({8{16'h3C40}}), 8'hFE);
        send_position({{7{16'h0000}}, 16'hFF81}, 8'h01);

        // byte width and depth disagree, mixes leave the word range
        set_format(2'd1, 5'd16);
        send_position(t_samples'({8{16'h007F}}), 8'hFF);
        send_position(t_samples'({8{16'h0080}}), 8'hFF);
        set_format(2'd2, 5'd8);
        send_position(t_samples'({8{16'h7FFF}}), 8'hFF);
        send_position(t_samples'({8{16'h8000}}), 8'hFF);

        for (int p = 0; p < 9; p++) begin
            set_format(2'(fmt_bytes[p]), 5'(fmt_depth[p]));
            idle_pct = fmt_idle[p];
            send_random(fmt_count[p]);
        end
        set_format(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
        idle_pct = 25;
        send_random(80);

        // closing stretch at full rate
        set_format(2'd2, 5'd16);
        calm = 1'b1;
        send_random(60);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (sb.pending_mix.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("%0d sample positions mixed under %0d sample formats, %0d words checked",
                 positions, formats, sb.checked);
        $display("%0d mismatches, %0d words still pending", sb.faults, sb.pending_mix.size());
        if (sb.faults == 0 && sb.pending_mix.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/scam_pkg.sv
rtl/scam_udiv.sv
rtl/scam_cell.sv
rtl/soft_clip_audio_mixer.sv
rtl/scam_checker.sv
tb/tb.sv
